>>> src/cfbd_pkg.sv
package cfbd_pkg;

    // Scan window: digits start DIGIT_OFFSET characters after the match.
    localparam int FREQ_DIGITS  = 6;
    localparam int DIGIT_OFFSET = 4;

    localparam logic [7:0]  CHAR_SEMI   = 8'd59;
    localparam logic [7:0]  CHAR_ZERO   = 8'd48;
    localparam logic [7:0]  CHAR_NINE   = 8'd57;
    localparam logic [7:0]  CHAR_LOW_A  = 8'd97;
    localparam logic [7:0]  CHAR_LOW_Z  = 8'd122;
    localparam logic [7:0]  CHAR_CASE   = 8'd32;
    localparam logic [7:0]  CHAR_UP_A   = 8'd65;
    localparam logic [7:0]  CHAR_UP_F   = 8'd70;
    localparam logic [7:0]  CHAR_UP_I   = 8'd73;
    localparam logic [7:0]  CHAR_STAR   = 8'd42;
    localparam logic [7:0]  CHAR_CR     = 8'd13;

    localparam logic [19:0] VALUE_MAX    = 20'hFFFFF;
    localparam logic [3:0]  POS_MAX      = 4'd15;
    localparam logic [3:0]  BAND_UNKNOWN = 4'd11;
    localparam logic [9:0]  CHAN_UNKNOWN = 10'd999;
    localparam int          NUM_BANDS    = 11;

    // Item kinds carried on tuser.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TUNER  = 1'b1;

    // Word indexes within one output burst.
    localparam logic [2:0] IDX_REPORT = 3'd0;
    localparam logic [2:0] IDX_STAR   = 3'd1;
    localparam logic [2:0] IDX_F      = 3'd2;
    localparam logic [2:0] IDX_HUND   = 3'd3;
    localparam logic [2:0] IDX_TENS   = 3'd4;
    localparam logic [2:0] IDX_ONES   = 3'd5;
    localparam logic [2:0] IDX_CR     = 3'd6;

    // Band table: inclusive kHz range, subtraction base, first channel and
    // reciprocal (multiplier and shift) that stands in for the channel step.
    localparam logic [19:0] BAND_LO [NUM_BANDS] = '{
        20'd1800, 20'd3500, 20'd5330, 20'd7000, 20'd10100, 20'd14000,
        20'd18068, 20'd21000, 20'd24890, 20'd28000, 20'd50000};
    localparam logic [19:0] BAND_HI [NUM_BANDS] = '{
        20'd2000, 20'd4000, 20'd5410, 20'd7300, 20'd10150, 20'd14350,
        20'd18168, 20'd21450, 20'd24990, 20'd29700, 20'd54000};
    // The 17 m base sits below the range start on purpose.
    localparam logic [19:0] BAND_BASE [NUM_BANDS] = '{
        20'd1800, 20'd3500, 20'd5330, 20'd7000, 20'd10100, 20'd14000,
        20'd18060, 20'd21000, 20'd24890, 20'd28000, 20'd50000};
    localparam logic [9:0] BAND_CHAN [NUM_BANDS] = '{
        10'd10, 10'd40, 10'd100, 10'd110, 10'd150, 10'd160,
        10'd200, 10'd220, 10'd270, 10'd290, 10'd360};
    // Divide by 10: x*205>>11, by 25: x*1311>>15, by 100: x*1311>>17.
    localparam logic [10:0] BAND_RECIP [NUM_BANDS] = '{
        11'd205, 11'd205, 11'd205, 11'd205, 11'd205, 11'd205,
        11'd205, 11'd205, 11'd205, 11'd1311, 11'd1311};
    localparam logic [4:0] BAND_SHIFT [NUM_BANDS] = '{
        5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11,
        5'd11, 5'd11, 5'd11, 5'd15, 5'd17};

    // Match and digit scan state for one two-letter command.
    typedef struct packed {
        logic        found;
        logic [3:0]  pos;
        logic [19:0] value;
        logic        ended;
    } t_scan;

endpackage

>>> src/cat_frequency_band_decoder_unit.sv
// Channel  | Direction | Signals                   | Word contents
// ---------+-----------+---------------------------+------------------------------
// s_axis   | in        | tvalid tready tdata[7:0]  | rx_byte
// m_axis   | out       | tvalid tready tdata[23:0] | band, channel, changed, char
//          |           | tuser[0] tlast            | item_kind, last_of_run
//
// One input byte is taken every cycle while s_axis_tready is high. A ';' that
// closes a message with a match queues one job; the job passes a band lookup
// stage and a channel stage into the output burst registers. It leaves as a
// burst of 1 or 7 words, one word per cycle while m_axis_tready is high. Input
// stalls while the job slot holds a job that the lookup stage cannot take.
// Reset is synchronous, active low, and clears all scan and job state.
module cat_frequency_band_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] band_code, [13:4] tuner_channel,
                                        // [14] band_changed, [22:15] tuner_char,
                                        // [23] zero
    output logic [0:0]  m_axis_tuser,   // [0] item_kind
    output logic        m_axis_tlast    // last_of_run
);
    import cfbd_pkg::*;

    // Scan state for the two commands.
    t_scan       r_fa, n_fa;
    t_scan       r_ifm, n_ifm;
    logic [7:0]  r_prev, n_prev;

    // Job slot, band lookup stage and output burst.
    logic        r_j_valid;
    logic [19:0] r_j_freq;
    logic        r_a_valid;
    logic [3:0]  r_a_band;
    logic [11:0] r_a_diff;
    logic        r_o_active;
    logic [2:0]  r_idx;
    logic [2:0]  r_last_idx;
    logic [3:0]  r_band;
    logic [9:0]  r_chan;
    logic        r_changed;
    logic [3:0]  r_cur_band;
    logic [9:0]  r_cur_chan;

    // Channel digit pipeline.
    logic [3:0]  r_hund;
    logic [6:0]  r_rem;
    logic [3:0]  r_tens;

    logic        in_acc;
    logic        is_semi;
    logic [7:0]  up_char;
    logic        burst_done;
    logic        burst_free;
    logic        a_move;
    logic        a_free;
    logic        j_move;
    logic        j_free;
    logic [3:0]  look_band;
    logic [11:0] look_diff;
    logic [22:0] q_prod;
    logic [9:0]  load_chan;
    logic [15:0] hund_prod;
    logic [9:0]  rem_full;
    logic [14:0] tens_prod;
    logic [6:0]  ones_full;
    logic [7:0]  out_char;

    // Feed one uppercased character to a two-letter matcher.
    function automatic t_scan f_scan(t_scan s, logic [7:0] prev, logic [7:0] c,
                                     logic [7:0] first, logic [7:0] second);
        t_scan       r;
        logic [24:0] v;
        r = s;
        v = '0;
        if (!s.found) begin
            if (prev == first && c == second) begin
                r.found = 1'b1;
                r.pos   = 4'd1;
            end
        end else begin
            if (s.pos != POS_MAX) r.pos = s.pos + 4'd1;
            if (!s.ended && {1'b0, r.pos} >= 5'(DIGIT_OFFSET) &&
                {1'b0, r.pos} < 5'(DIGIT_OFFSET + FREQ_DIGITS)) begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                    v = {2'b0, s.value, 3'b0} + {4'b0, s.value, 1'b0}
                        + {17'b0, c - CHAR_ZERO};
                    r.value = (v > {5'b0, VALUE_MAX}) ? VALUE_MAX : v[19:0];
                end else begin
                    r.ended = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Handshakes and stage flow.
    assign burst_done    = r_o_active && m_axis_tready && (r_idx == r_last_idx);
    assign burst_free    = !r_o_active || burst_done;
    assign a_move        = r_a_valid && burst_free;
    assign a_free        = !r_a_valid || a_move;
    assign j_move        = r_j_valid && a_free;
    assign j_free        = !r_j_valid || j_move;
    assign s_axis_tready = j_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_semi       = (s_axis_tdata == CHAR_SEMI);

    // Uppercase and scan the incoming word.
    always_comb begin
        up_char = s_axis_tdata;
        if (s_axis_tdata >= CHAR_LOW_A && s_axis_tdata <= CHAR_LOW_Z)
            up_char = s_axis_tdata - CHAR_CASE;
        n_fa   = r_fa;
        n_ifm  = r_ifm;
        n_prev = r_prev;
        if (in_acc) begin
            if (is_semi) begin
                n_fa   = '0;
                n_ifm  = '0;
                n_prev = '0;
            end else begin
                n_fa   = f_scan(r_fa, r_prev, up_char, CHAR_UP_F, CHAR_UP_A);
                n_ifm  = f_scan(r_ifm, r_prev, up_char, CHAR_UP_I, CHAR_UP_F);
                n_prev = up_char;
            end
        end
    end

    // Band lookup over the disjoint ranges.
    always_comb begin
        look_band = BAND_UNKNOWN;
        look_diff = '0;
        for (int b = 0; b < NUM_BANDS; b++) begin
            if (r_j_freq >= BAND_LO[b] && r_j_freq <= BAND_HI[b]) begin
                look_band = 4'(b);
                look_diff = 12'(r_j_freq - BAND_BASE[b]);
            end
        end
    end

    // Channel from the band offset by reciprocal multiplication.
    always_comb begin
        q_prod    = '0;
        load_chan = CHAN_UNKNOWN;
        if (r_a_band != BAND_UNKNOWN) begin
            q_prod    = ({11'b0, r_a_diff} * {12'b0, BAND_RECIP[r_a_band]})
                        >> BAND_SHIFT[r_a_band];
            load_chan = BAND_CHAN[r_a_band] + q_prod[9:0];
        end
    end

    // Digit split of the held channel: hundreds, remainder, tens, ones.
    assign hund_prod = {6'b0, r_chan} * 16'd41;
    assign rem_full  = r_chan - 10'({r_hund, 6'b0} + {r_hund, 5'b0} + {r_hund, 2'b0});
    assign tens_prod = {8'b0, r_rem} * 15'd205;
    assign ones_full = r_rem - 7'({r_tens, 3'b0} + {r_tens, 1'b0});

    // Output word selection.
    always_comb begin
        case (r_idx)
            IDX_REPORT: out_char = 8'd0;
            IDX_STAR:   out_char = CHAR_STAR;
            IDX_F:      out_char = CHAR_UP_F;
            IDX_HUND:   out_char = CHAR_ZERO + {4'b0, r_hund};
            IDX_TENS:   out_char = CHAR_ZERO + {4'b0, r_tens};
            IDX_ONES:   out_char = CHAR_ZERO + {4'b0, ones_full[3:0]};
            IDX_CR:     out_char = CHAR_CR;
            default:    out_char = 8'd0;
        endcase
    end

    assign m_axis_tvalid = r_o_active;
    assign m_axis_tlast  = (r_idx == r_last_idx);
    assign m_axis_tuser  = (r_idx == IDX_REPORT) ? KIND_REPORT : KIND_TUNER;
    assign m_axis_tdata  = {1'b0, out_char, (r_idx == IDX_REPORT) && r_changed,
                            r_chan, r_band};

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa       <= '0;
            r_ifm      <= '0;
            r_prev     <= '0;
            r_j_valid  <= 1'b0;
            r_a_valid  <= 1'b0;
            r_o_active <= 1'b0;
            r_idx      <= IDX_REPORT;
            r_last_idx <= IDX_REPORT;
            r_cur_band <= BAND_UNKNOWN;
            r_cur_chan <= CHAN_UNKNOWN;
        end else begin
            r_fa   <= n_fa;
            r_ifm  <= n_ifm;
            r_prev <= n_prev;
            if (in_acc && is_semi && (r_fa.found || r_ifm.found))
                r_j_valid <= 1'b1;
            else if (j_move)
                r_j_valid <= 1'b0;
            if (j_move)
                r_a_valid <= 1'b1;
            else if (a_move)
                r_a_valid <= 1'b0;
            if (a_move) begin
                r_o_active <= 1'b1;
                r_idx      <= IDX_REPORT;
                r_last_idx <= (load_chan != r_cur_chan) ? IDX_CR : IDX_REPORT;
                r_cur_band <= r_a_band;
                r_cur_chan <= load_chan;
            end else if (burst_done) begin
                r_o_active <= 1'b0;
            end else if (r_o_active && m_axis_tready) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc && is_semi)
            r_j_freq <= r_fa.found ? r_fa.value : r_ifm.value;
        if (j_move) begin
            r_a_band <= look_band;
            r_a_diff <= look_diff;
        end
        if (a_move) begin
            r_band    <= r_a_band;
            r_chan    <= load_chan;
            r_changed <= (r_a_band != r_cur_band);
        end
        // Hundreds and remainder settle first, then tens, before the hundreds word.
        r_hund <= hund_prod[15:12];
        r_rem  <= rem_full[6:0];
        r_tens <= tens_prod[14:11];
    end

endmodule

>>> test/frequency_band_checker.sv
module frequency_band_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [3:0] band_code, [13:4] tuner_channel,
                                        // [14] band_changed, [22:15] tuner_char
    input  logic [0:0]  m_axis_tuser,   // [0] item_kind
    input  logic        m_axis_tlast,   // last_of_run
    output int          o_fail_count,
    output int          o_pending
);
    import cfbd_pkg::*;

    // One output word as the decoder should emit it.
    typedef struct packed {
        logic       kind;
        logic [3:0] band;
        logic [9:0] chan;
        logic       changed;
        logic [7:0] tuner_char;
        logic       last;
    } t_band_word;

    // Amateur band table, inclusive kHz limits. The 17 m channel origin is
    // 18060 while the band itself only opens at 18068.
    localparam int BAND_FLOOR [NUM_BANDS] = '{
        1800, 3500, 5330, 7000, 10100, 14000, 18068, 21000, 24890, 28000, 50000};
    localparam int BAND_CEIL [NUM_BANDS] = '{
        2000, 4000, 5410, 7300, 10150, 14350, 18168, 21450, 24990, 29700, 54000};
    localparam int CHAN_ORIGIN [NUM_BANDS] = '{
        1800, 3500, 5330, 7000, 10100, 14000, 18060, 21000, 24890, 28000, 50000};
    localparam int CHAN_FIRST [NUM_BANDS] = '{
        10, 40, 100, 110, 150, 160, 200, 220, 270, 290, 360};
    localparam int CHAN_STEP [NUM_BANDS] = '{
        10, 10, 10, 10, 10, 10, 10, 10, 10, 25, 100};

    t_band_word  band_words_due[$];
    logic [3:0]  tuned_band;
    logic [9:0]  tuned_chan;
    logic [7:0]  prior_char;
    t_scan       fa_scan;
    t_scan       if_scan;
    int          words_seen;

    // Advance one two-letter command scan by one uppercased character.
    function automatic t_scan advance_scan(input t_scan s, input logic [7:0] lead,
                                           input logic [7:0] trail, input logic [7:0] ch,
                                           input logic [7:0] prior);
        t_scan r;
        int    acc;
        r = s;
        if (!r.found) begin
            if (prior == lead && ch == trail) begin
                r.found = 1'b1;
                r.pos   = 4'd1;
            end
            return r;
        end
        if (r.pos < POS_MAX) begin
            r.pos = r.pos + 4'd1;
        end
        if (!r.ended && r.pos >= DIGIT_OFFSET && r.pos < DIGIT_OFFSET + FREQ_DIGITS) begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                acc = int'(r.value) * 10 + int'(ch - CHAR_ZERO);
                r.value = (acc > int'(VALUE_MAX)) ? VALUE_MAX : acc[19:0];
            end else begin
                r.ended = 1'b1;
            end
        end
        return r;
    endfunction

    // Frequency in kHz to band code and tuner channel.
    function automatic void map_frequency(input int khz, output logic [3:0] band,
                                          output logic [9:0] chan);
        int ch_num;
        band = BAND_UNKNOWN;
        chan = CHAN_UNKNOWN;
        for (int i = 0; i < NUM_BANDS; i++) begin
            if (khz >= BAND_FLOOR[i] && khz <= BAND_CEIL[i]) begin
                ch_num = CHAN_FIRST[i] + (khz - CHAN_ORIGIN[i]) / CHAN_STEP[i];
                band   = i[3:0];
                chan   = ch_num[9:0];
            end
        end
    endfunction

    // Work out the words that one received character causes.
    function automatic void predict_rx(input logic [7:0] rx);
        logic [7:0] up;
        logic [3:0] band;
        logic [9:0] chan;
        logic [7:0] cmd [6];
        int         khz;
        int         n;
        t_band_word w;
        if (rx != CHAR_SEMI) begin
            up = (rx >= CHAR_LOW_A && rx <= CHAR_LOW_Z) ? rx - CHAR_CASE : rx;
            fa_scan = advance_scan(fa_scan, CHAR_UP_F, CHAR_UP_A, up, prior_char);
            if_scan = advance_scan(if_scan, CHAR_UP_I, CHAR_UP_F, up, prior_char);
            prior_char = up;
            return;
        end
        // End of message: FA wins over IF; no match means no words.
        if (fa_scan.found || if_scan.found) begin
            khz = fa_scan.found ? int'(fa_scan.value) : int'(if_scan.value);
            map_frequency(khz, band, chan);
            w.kind       = KIND_REPORT;
            w.band       = band;
            w.chan       = chan;
            w.changed    = (band != tuned_band);
            w.tuner_char = 8'd0;
            w.last       = (chan == tuned_chan);
            band_words_due.push_back(w);
            if (chan != tuned_chan) begin
                n = int'(chan);
                cmd[0] = CHAR_STAR;
                cmd[1] = CHAR_UP_F;
                cmd[2] = CHAR_ZERO + 8'(n / 100);
                cmd[3] = CHAR_ZERO + 8'((n / 10) % 10);
                cmd[4] = CHAR_ZERO + 8'(n % 10);
                cmd[5] = CHAR_CR;
                for (int k = 0; k < 6; k++) begin
                    w.kind       = KIND_TUNER;
                    w.changed    = 1'b0;
                    w.tuner_char = cmd[k];
                    w.last       = (k == 5);
                    band_words_due.push_back(w);
                end
            end
            tuned_band = band;
            tuned_chan = chan;
        end
        fa_scan    = '0;
        if_scan    = '0;
        prior_char = 8'd0;
    endfunction

    task automatic report_mismatch(input string detail);
        $display("[%0t] band decoder: %s", $time, detail);
        o_fail_count++;
    endtask

    // Compare one accepted output word with the oldest prediction.
    task automatic check_word();
        t_band_word got;
        t_band_word want;
        got.kind       = m_axis_tuser[0];
        got.band       = m_axis_tdata[3:0];
        got.chan       = m_axis_tdata[13:4];
        got.changed    = m_axis_tdata[14];
        got.tuner_char = m_axis_tdata[22:15];
        got.last       = m_axis_tlast;
        if (band_words_due.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with none outstanding", words_seen));
        end else begin
            want = band_words_due.pop_front();
            if (got.kind !== want.kind || got.band !== want.band || got.chan !== want.chan
                    || got.changed !== want.changed || got.tuner_char !== want.tuner_char
                    || got.last !== want.last) begin
                report_mismatch($sformatf(
                    {"word %0d got kind %0d band %0d chan %0d chg %0d char %02h last %0d,",
                     " want %0d %0d %0d %0d %02h %0d"},
                    words_seen, got.kind, got.band, got.chan, got.changed, got.tuner_char,
                    got.last, want.kind, want.band, want.chan, want.changed,
                    want.tuner_char, want.last));
            end
        end
        words_seen++;
    endtask

    // Watch both channels at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            band_words_due.delete();
            tuned_band = BAND_UNKNOWN;
            tuned_chan = CHAN_UNKNOWN;
            prior_char = 8'd0;
            fa_scan    = '0;
            if_scan    = '0;
            words_seen = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_rx(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_word();
            end
        end
        o_pending <= band_words_due.size();
    end

endmodule

>>> test/testbench.sv
module testbench;
    import cfbd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [3:0] band_code, [13:4] tuner_channel,
                                        // [14] band_changed, [22:15] tuner_char
    logic [0:0]  m_axis_tuser;          // [0] item_kind
    logic        m_axis_tlast;          // last_of_run

    int          band_faults;
    int          words_outstanding;

    logic [7:0]  line_buf[$];
    int          words_sent;
    int          messages_sent;
    int          burst_left;
    int          recent_khz = 14074;
    int          rx_mode;
    int          rx_phase;

    // Edges of every band, used to aim frequencies at the range limits.
    localparam int EDGE_KHZ [23] = '{
        1800, 2000, 3500, 4000, 5330, 5410, 7000, 7300, 10100, 10150, 14000,
        14350, 18060, 18068, 18168, 21000, 21450, 24890, 24990, 28000, 29700,
        50000, 54000};

    always #4 i_clk = ~i_clk;

    cat_frequency_band_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    frequency_band_checker band_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (band_faults),
        .o_pending     (words_outstanding)
    );

    // Receiver backpressure: a new pattern is drawn whenever rx_phase wraps to 0.
    always @(posedge i_clk) begin
        if (rx_phase == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        rx_phase <= (rx_phase == 47) ? 0 : rx_phase + 1;
        case (rx_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= $urandom_range(0, 1);
            end
            2: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_axis_tready <= (rx_phase % 4 != 3);
            end
        endcase
    end

    // Hand one word to the decoder; bursts end with a short random gap.
    task automatic send_rx_word(input logic [7:0] rx);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    // Stop sending until the decoder has delivered every outstanding word.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words_outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_message();
        foreach (line_buf[i]) begin
            send_rx_word(line_buf[i]);
        end
        line_buf.delete();
        messages_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endtask

    // FA or IF with each letter in random case.
    task automatic add_command(input bit use_fa);
        logic [7:0] lead;
        logic [7:0] trail;
        lead  = use_fa ? CHAR_UP_F : CHAR_UP_I;
        trail = use_fa ? CHAR_UP_A : CHAR_UP_F;
        if ($urandom_range(0, 1)) begin
            lead = lead + CHAR_CASE;
        end
        if ($urandom_range(0, 1)) begin
            trail = trail + CHAR_CASE;
        end
        line_buf.push_back(lead);
        line_buf.push_back(trail);
    endtask

    // Filler that never closes a message: digits, letters or other bytes.
    task automatic add_filler(input int count, input int flavor);
        logic [7:0] c;
        for (int i = 0; i < count; i++) begin
            case (flavor)
                0: c = CHAR_ZERO + 8'($urandom_range(0, 9));
                1: c = CHAR_UP_A + 8'($urandom_range(0, 25));
                2: c = CHAR_LOW_A + 8'($urandom_range(0, 25));
                default: begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CHAR_SEMI) begin
                        c = 8'd0;
                    end
                end
            endcase
            line_buf.push_back(c);
        end
    endtask

    // The frequency as decimal digits, sometimes with leading zeros.
    task automatic add_khz(input int khz);
        logic [7:0] dig [6];
        int         v;
        int         len;
        v   = khz;
        len = 0;
        for (int k = 0; k < 6; k++) begin
            dig[k] = CHAR_ZERO + 8'(v % 10);
            v = v / 10;
            if (dig[k] != CHAR_ZERO) begin
                len = k + 1;
            end
        end
        if (len == 0) begin
            len = 1;
        end
        for (int k = $urandom_range(len, 6) - 1; k >= 0; k--) begin
            line_buf.push_back(dig[k]);
        end
    endtask

    function automatic int pick_khz();
        int e;
        e = EDGE_KHZ[$urandom_range(0, 22)];
        case ($urandom_range(0, 9))
            0, 1, 2: pick_khz = e + $urandom_range(0, 2) - 1;
            3, 4:    pick_khz = e + $urandom_range(0, 400);
            5:       pick_khz = e;
            6:       pick_khz = recent_khz;
            7:       pick_khz = $urandom_range(0, 999999);
            default: pick_khz = $urandom_range(0, 999);
        endcase
    endfunction

    // A command with its two leading characters and the frequency digits.
    task automatic add_frequency_command(input bit use_fa);
        int khz;
        khz = pick_khz();
        recent_khz = khz;
        add_command(use_fa);
        add_filler(2, 0);
        add_khz(khz);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Lowercase match without digits, IF fallback, empty message,
        // zero and all-ones bytes, top of the 6 m band.
        add_text("fa00;");
        add_text("If001800;");
        add_text(";");
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        add_text("Fa0054000;");
        send_message();

        while (words_sent < 130) begin
            case ($urandom_range(0, 19))
                // Well-formed message, optional prefix and letter tail.
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                    add_filler($urandom_range(0, 3), $urandom_range(1, 2));
                    add_frequency_command($urandom_range(0, 1));
                    if ($urandom_range(0, 2) == 0) begin
                        add_filler($urandom_range(1, 14), $urandom_range(1, 2));
                    end
                    line_buf.push_back(CHAR_SEMI);
                end
                // Both commands in one message, in either order.
                11, 12, 13: begin
                    add_frequency_command($urandom_range(0, 1));
                    add_filler($urandom_range(0, 2), 1);
                    add_frequency_command($urandom_range(0, 1));
                    line_buf.push_back(CHAR_SEMI);
                end
                // Broken: message cut short or digits mixed with junk.
                14, 15, 16: begin
                    add_command($urandom_range(0, 1));
                    for (int i = $urandom_range(0, 8); i > 0; i--) begin
                        add_filler(1, ($urandom_range(0, 2) == 0) ? 3 : 0);
                    end
                    line_buf.push_back(CHAR_SEMI);
                end
                // Noise over the whole byte range.
                default: begin
                    for (int i = $urandom_range(1, 12); i > 0; i--) begin
                        line_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    if ($urandom_range(0, 1)) begin
                        line_buf.push_back(CHAR_SEMI);
                    end
                end
            endcase
            send_message();
            if (messages_sent == 5) begin
                drain_results();
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (band_faults == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
